// ----- rtl/assert_macros.svh -----
// Assertion macros used by the blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BB3_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BB3_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/bb3_pkg.sv -----
// Shared types and constants of the 3x3 box blur.
package bb3_pkg;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;
    localparam int COORD_W    = 12;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    localparam logic [CFG_DATA_W-1:0] HEIGHT_LIMIT = 13'd4096;

    typedef enum logic [1:0] {
        F_IDLE,
        F_UPD,
        F_HOLD
    } bb3_fstate_t;

    typedef struct packed {
        logic [3:0]         slots;
        logic [2:0]         row_ok;
        logic [2:0]         col_ok;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } bb3_ctrl_t;

endpackage

// ----- rtl/bb3_fifo.sv -----
// Two-entry queue between the front and back parts of the blur.
module bb3_fifo #(
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] push_data,
    input  logic          pop,
    output logic [DW-1:0] head_data,
    output logic          empty,
    output logic          full
);

    logic [DW-1:0] mem_reg [2];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    assign empty     = (cnt_reg == 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/bb3_front.sv -----
// Front part: accepts pixels, keeps line stores and window, classifies results.
module bb3_front #(
    parameter int MAX_WIDTH    = 4096,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [CHANNEL_BITS-1:0]           red_in,
    input  logic [CHANNEL_BITS-1:0]           green_in,
    input  logic [CHANNEL_BITS-1:0]           blue_in,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              q_full,
    output logic                              q_push,
    output bb3_pkg::bb3_ctrl_t                q_ctrl,
    output logic [9*3*CHANNEL_BITS-1:0]       q_win
);

    localparam int PW = 3 * CHANNEL_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    bb3_pkg::bb3_fstate_t state_reg;
    bb3_pkg::bb3_fstate_t state_next;

    logic [bb3_pkg::COORD_W-1:0]    row_reg;
    logic [bb3_pkg::COORD_W-1:0]    row_next;
    logic [CW-1:0]                  col_reg;
    logic [CW-1:0]                  col_next;
    logic [bb3_pkg::CFG_DATA_W-1:0] width_cfg_reg;
    logic [bb3_pkg::CFG_DATA_W-1:0] height_cfg_reg;
    logic [PW-1:0]                  pix_reg;
    logic [PW-1:0]                  prior_mem [MAX_WIDTH];
    logic [PW-1:0]                  second_mem [MAX_WIDTH];
    logic [PW-1:0]                  prior_rd_reg;
    logic [PW-1:0]                  second_rd_reg;
    logic [PW-1:0]                  win_reg [9];
    logic [PW-1:0]                  win_next [9];
    bb3_pkg::bb3_ctrl_t             ent_ctrl_reg;
    bb3_pkg::bb3_ctrl_t             ent_ctrl_next;
    logic [9*PW-1:0]                ent_win_reg;
    logic [9*PW-1:0]                ent_win_next;

    logic [WW-1:0]                  eff_w;
    logic [bb3_pkg::CFG_DATA_W-1:0] eff_h;
    logic                           last_col;
    logic                           last_row;
    logic                           accept;
    logic                           cfg_write;
    logic                           any_slot;

    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && ((cfg_index == bb3_pkg::REG_IMAGE_WIDTH)
                                  || (cfg_index == bb3_pkg::REG_IMAGE_HEIGHT));

    always_comb
    begin
        if (width_cfg_reg == '0)
        begin
            eff_w = WW'(1);
        end
        else if (32'(width_cfg_reg) > 32'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0)
        begin
            eff_h = 13'd1;
        end
        else if (height_cfg_reg > bb3_pkg::HEIGHT_LIMIT)
        begin
            eff_h = bb3_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            eff_h = height_cfg_reg;
        end
    end

    assign last_col = ((WW'(col_reg) + WW'(1)) == eff_w);
    assign last_row = (({1'b0, row_reg} + 13'd1) == eff_h);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3 + 1];
            win_next[i*3 + 1] = win_reg[i*3 + 2];
        end
        win_next[2] = second_rd_reg;
        win_next[5] = prior_rd_reg;
        win_next[8] = pix_reg;
        for (int k = 0; k < 9; k++)
        begin
            ent_win_next[k*PW +: PW] = win_next[k];
        end
        ent_ctrl_next.slots[0] = (row_reg != '0) && (col_reg != '0);
        ent_ctrl_next.slots[1] = (row_reg != '0) && last_col;
        ent_ctrl_next.slots[2] = last_row && (col_reg != '0);
        ent_ctrl_next.slots[3] = last_row && last_col;
        ent_ctrl_next.row_ok   = {1'b1, row_reg != '0, row_reg > 12'd1};
        ent_ctrl_next.col_ok   = {1'b1, col_reg != '0, col_reg > CW'(1)};
        ent_ctrl_next.row      = row_reg;
        ent_ctrl_next.col      = bb3_pkg::COORD_W'(col_reg);
        any_slot = (ent_ctrl_next.slots != 4'd0);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bb3_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    state_next = bb3_pkg::F_UPD;
                end
            end
            bb3_pkg::F_UPD:
            begin
                if (any_slot && q_full)
                begin
                    state_next = bb3_pkg::F_HOLD;
                end
                else
                begin
                    state_next = bb3_pkg::F_IDLE;
                end
            end
            bb3_pkg::F_HOLD:
            begin
                if (!q_full)
                begin
                    state_next = bb3_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = bb3_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        q_push   = 1'b0;
        q_ctrl   = ent_ctrl_next;
        q_win    = ent_win_next;
        unique case (state_reg)
            bb3_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
            end
            bb3_pkg::F_UPD:
            begin
                q_push = any_slot && !q_full;
            end
            bb3_pkg::F_HOLD:
            begin
                q_push = !q_full;
                q_ctrl = ent_ctrl_reg;
                q_win  = ent_win_reg;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_write)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (state_reg == bb3_pkg::F_UPD)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + 12'd1;
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bb3_pkg::F_IDLE;
            row_reg        <= '0;
            col_reg        <= '0;
            width_cfg_reg  <= 13'd640;
            height_cfg_reg <= 13'd480;
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            if (cfg_valid && (cfg_index == bb3_pkg::REG_IMAGE_WIDTH))
            begin
                width_cfg_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == bb3_pkg::REG_IMAGE_HEIGHT))
            begin
                height_cfg_reg <= cfg_data;
            end
            if (state_reg == bb3_pkg::F_UPD)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    win_reg[k] <= win_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg       <= {red_in, green_in, blue_in};
            prior_rd_reg  <= prior_mem[col_reg];
            second_rd_reg <= second_mem[col_reg];
        end
        if (state_reg == bb3_pkg::F_UPD)
        begin
            ent_ctrl_reg <= ent_ctrl_next;
            ent_win_reg  <= ent_win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bb3_pkg::F_UPD)
        begin
            prior_mem[col_reg]  <= pix_reg;
            second_mem[col_reg] <= prior_rd_reg;
        end
    end

endmodule

// ----- rtl/bb3_back.sv -----
// Back part: sums each window region, divides by the neighbor count, drives results.
module bb3_back #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  bb3_pkg::bb3_ctrl_t            q_ctrl,
    input  logic [9*3*CHANNEL_BITS-1:0]   q_win,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CHANNEL_BITS-1:0]       red_out,
    output logic [CHANNEL_BITS-1:0]       green_out,
    output logic [CHANNEL_BITS-1:0]       blue_out,
    output logic [bb3_pkg::COORD_W-1:0]   out_row,
    output logic [bb3_pkg::COORD_W-1:0]   out_column,
    output logic                          last_of_run,
    output logic                          last_of_frame
);

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 3 * CB;
    localparam int SB = CB + 4;
    localparam logic [SB-1:0] M1 = SB'((1 << SB) - 1);
    localparam logic [SB-1:0] M2 = SB'(1 << (SB - 1));
    localparam logic [SB-1:0] M3 = SB'(((1 << SB) - 1) / 3);
    localparam logic [SB-1:0] M4 = SB'(1 << (SB - 2));
    localparam logic [SB-1:0] M6 = SB'(((1 << SB) - 1) / 6);
    localparam logic [SB-1:0] M9 = SB'(((1 << SB) - 1) / 9);

    logic                        en;
    logic [3:0]                  done_reg;
    logic [3:0]                  done_next;
    logic [3:0]                  remaining;
    logic [1:0]                  sel;
    logic                        issue;
    logic                        is_last;
    logic [2:0]                  rr;
    logic [2:0]                  cc;
    logic [8:0]                  mask;
    logic [SB-1:0]               sum_c [3];
    logic [SB-1:0]               recip;

    logic                        a_v_reg;
    logic [SB-1:0]               a_sum_reg [3];
    logic [3:0]                  a_cnt_reg;
    logic [bb3_pkg::COORD_W-1:0] a_row_reg;
    logic [bb3_pkg::COORD_W-1:0] a_col_reg;
    logic                        a_lor_reg;
    logic                        a_lof_reg;

    logic                        b_v_reg;
    logic [2*SB-1:0]             b_prod_reg [3];
    logic [SB-1:0]               b_sum_reg [3];
    logic [3:0]                  b_cnt_reg;
    logic [bb3_pkg::COORD_W-1:0] b_row_reg;
    logic [bb3_pkg::COORD_W-1:0] b_col_reg;
    logic                        b_lor_reg;
    logic                        b_lof_reg;

    logic                        o_v_reg;
    logic [CB-1:0]               o_ch_reg [3];
    logic [bb3_pkg::COORD_W-1:0] o_row_reg;
    logic [bb3_pkg::COORD_W-1:0] o_col_reg;
    logic                        o_lor_reg;
    logic                        o_lof_reg;
    logic [CB-1:0]               quo [3];

    assign en = !o_v_reg || out_ready;

    always_comb
    begin
        remaining = q_ctrl.slots & ~done_reg;
        priority if (remaining[0])
        begin
            sel = 2'd0;
        end
        else if (remaining[1])
        begin
            sel = 2'd1;
        end
        else if (remaining[2])
        begin
            sel = 2'd2;
        end
        else
        begin
            sel = 2'd3;
        end
        issue   = en && !q_empty;
        is_last = ((remaining & ~(4'd1 << sel)) == 4'd0);
        q_pop   = issue && is_last;
        done_next = done_reg;
        if (issue)
        begin
            done_next = is_last ? 4'd0 : (done_reg | (4'd1 << sel));
        end
        rr = sel[1] ? 3'b110 : 3'b111;
        cc = sel[0] ? 3'b110 : 3'b111;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                mask[i*3 + j] = rr[i] & cc[j] & q_ctrl.row_ok[i] & q_ctrl.col_ok[j];
            end
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_c[ch] = '0;
            for (int k = 0; k < 9; k++)
            begin
                if (mask[k])
                begin
                    sum_c[ch] = sum_c[ch] + SB'(q_win[k*PW + (2 - ch)*CB +: CB]);
                end
            end
        end
    end

    always_comb
    begin
        unique case (a_cnt_reg)
            4'd1:    recip = M1;
            4'd2:    recip = M2;
            4'd3:    recip = M3;
            4'd4:    recip = M4;
            4'd6:    recip = M6;
            4'd9:    recip = M9;
            default: recip = M1;
        endcase
    end

    always_comb
    begin
        logic [SB-1:0] q0;
        logic [SB-1:0] rem;
        for (int ch = 0; ch < 3; ch++)
        begin
            q0  = b_prod_reg[ch][2*SB-1:SB];
            rem = b_sum_reg[ch] - SB'(q0 * b_cnt_reg);
            if (rem >= SB'(b_cnt_reg))
            begin
                q0 = q0 + SB'(1);
            end
            quo[ch] = CB'(q0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 4'd0;
            a_v_reg  <= 1'b0;
            b_v_reg  <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            if (en)
            begin
                a_v_reg <= issue;
                b_v_reg <= a_v_reg;
                o_v_reg <= b_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                a_sum_reg[ch]  <= sum_c[ch];
                b_prod_reg[ch] <= a_sum_reg[ch] * recip;
                b_sum_reg[ch]  <= a_sum_reg[ch];
                o_ch_reg[ch]   <= quo[ch];
            end
            a_cnt_reg <= 4'($countones(mask));
            a_row_reg <= q_ctrl.row - (sel[1] ? 12'd0 : 12'd1);
            a_col_reg <= q_ctrl.col - (sel[0] ? 12'd0 : 12'd1);
            a_lor_reg <= is_last;
            a_lof_reg <= (sel == 2'd3);
            b_cnt_reg <= a_cnt_reg;
            b_row_reg <= a_row_reg;
            b_col_reg <= a_col_reg;
            b_lor_reg <= a_lor_reg;
            b_lof_reg <= a_lof_reg;
            o_row_reg <= b_row_reg;
            o_col_reg <= b_col_reg;
            o_lor_reg <= b_lor_reg;
            o_lof_reg <= b_lof_reg;
        end
    end

    assign out_valid     = o_v_reg;
    assign red_out       = o_ch_reg[0];
    assign green_out     = o_ch_reg[1];
    assign blue_out      = o_ch_reg[2];
    assign out_row       = o_row_reg;
    assign out_column    = o_col_reg;
    assign last_of_run   = o_lor_reg;
    assign last_of_frame = o_lof_reg;

endmodule

// ----- rtl/box_blur_3x3_edge_normalized.sv -----
// Top level of the edge-normalized 3x3 box blur on a raster-order RGB stream.
// Pixels enter on in_valid/in_ready in raster order; each result leaves on
// out_valid/out_ready with its row, column and two end markers.
// The image size is set through the cfg channel (index 0 width, 1 height),
// which is always ready; a write restarts the frame at row 0, column 0.
// The front part accepts a pixel in its idle state, reading both line stores, and
// takes no other until it has updated the stores and window and queued the work.
// Each pixel yields up to four results, most of them one; the back part issues
// one result per cycle, unless its output stalls, into a three-stage sum, multiply
// and correction pipeline. The first result of a pixel passes the front's update
// state, the queue and the back stages before out_valid shows it, one row and one
// column behind the input. On the last row of a frame taller than one row most
// pixels yield two results, which the back part issues one after the other.
// A stalled receiver holds the back pipeline; the two-entry queue then fills
// and the front stops taking pixels until space frees up.
// Reset clears the counters and window, sets 640 by 480, and empties the queue;
// the line stores are not cleared and need no clearing pass.
`include "assert_macros.svh"
module box_blur_3x3_edge_normalized #(
    parameter int MAX_WIDTH    = 4096,
    parameter int CHANNEL_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [CHANNEL_BITS-1:0]        red_in,
    input  logic [CHANNEL_BITS-1:0]        green_in,
    input  logic [CHANNEL_BITS-1:0]        blue_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [CHANNEL_BITS-1:0]        red_out,
    output logic [CHANNEL_BITS-1:0]        green_out,
    output logic [CHANNEL_BITS-1:0]        blue_out,
    output logic [bb3_pkg::COORD_W-1:0]    out_row,
    output logic [bb3_pkg::COORD_W-1:0]    out_column,
    output logic                           last_of_run,
    output logic                           last_of_frame,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int WINW = 9 * 3 * CHANNEL_BITS;
    localparam int CTW  = $bits(bb3_pkg::bb3_ctrl_t);

    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    bb3_pkg::bb3_ctrl_t push_ctrl;
    bb3_pkg::bb3_ctrl_t head_ctrl;
    logic [WINW-1:0]    push_win;
    logic [WINW-1:0]    head_win;
    logic [CTW+WINW-1:0] head_data;

    bb3_front #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctrl    (push_ctrl),
        .q_win     (push_win)
    );

    bb3_fifo #(
        .DW (CTW + WINW)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({push_ctrl, push_win}),
        .pop       (q_pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign head_ctrl = head_data[CTW+WINW-1:WINW];
    assign head_win  = head_data[WINW-1:0];

    bb3_back #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_ctrl        (head_ctrl),
        .q_win         (head_win),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .out_row       (out_row),
        .out_column    (out_column),
        .last_of_run   (last_of_run),
        .last_of_frame (last_of_frame)
    );

    `BB3_ASSERT_IMPL(a_no_push_when_full, clk, rst_n, q_push, !q_full)
    `BB3_ASSERT_IMPL(a_no_pop_when_empty, clk, rst_n, q_pop, !q_empty)
    `BB3_ASSERT_IMPL(a_frame_end_ends_run, clk, rst_n, out_valid && last_of_frame, last_of_run)
    `BB3_ASSERT_NEXT(a_one_pixel_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// ----- tb/blur_checker.sv -----
// Checker that predicts the 3x3 box blur results and compares them with the block's output.
module blur_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic [7:0]                     red_in,
    input  logic [7:0]                     green_in,
    input  logic [7:0]                     blue_in,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [7:0]                     red_out,
    input  logic [7:0]                     green_out,
    input  logic [7:0]                     blue_out,
    input  logic [bb3_pkg::COORD_W-1:0]    out_row,
    input  logic [bb3_pkg::COORD_W-1:0]    out_column,
    input  logic                           last_of_run,
    input  logic                           last_of_frame,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             pending,
    output int                             fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 4096;

    typedef struct packed {
        logic [7:0]                  red;
        logic [7:0]                  green;
        logic [7:0]                  blue;
        logic [bb3_pkg::COORD_W-1:0] row;
        logic [bb3_pkg::COORD_W-1:0] col;
        logic                        run_end;
        logic                        frame_end;
    } blur_pixel_t;

    blur_pixel_t                    blurred_q[$];
    logic [23:0]                    line_above[LINE_DEPTH];
    logic [23:0]                    line_two_above[LINE_DEPTH];
    logic [23:0]                    win[3][3];
    int                             row_pos;
    int                             col_pos;
    logic [bb3_pkg::CFG_DATA_W-1:0] width_reg;
    logic [bb3_pkg::CFG_DATA_W-1:0] height_reg;

    assign pending = blurred_q.size();

    function automatic blur_pixel_t blur_at(int orow, int ocol, int r, int c, int w, int h);
        blur_pixel_t res;
        int          sr;
        int          sg;
        int          sb;
        int          cnt;
        int          nr;
        int          nc;
        int          wr;
        int          wc;
        sr = 0;
        sg = 0;
        sb = 0;
        cnt = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                nr = orow + dr;
                nc = ocol + dc;
                wr = nr - r + 2;
                wc = nc - c + 2;
                if (nr >= 0 && nr < h && nc >= 0 && nc < w && wr >= 0 && wr <= 2
                    && wc >= 0 && wc <= 2)
                begin
                    sr += win[wr][wc][23:16];
                    sg += win[wr][wc][15:8];
                    sb += win[wr][wc][7:0];
                    cnt++;
                end
            end
        end
        if (cnt == 0)
            cnt = 1;
        res.red = 8'(sr / cnt);
        res.green = 8'(sg / cnt);
        res.blue = 8'(sb / cnt);
        res.row = bb3_pkg::COORD_W'(orow);
        res.col = bb3_pkg::COORD_W'(ocol);
        res.run_end = 1'b0;
        res.frame_end = (orow == h - 1 && ocol == w - 1);
        return res;
    endfunction

    task automatic take_pixel(logic [23:0] pix);
        int          w;
        int          h;
        int          r;
        int          c;
        int          n;
        blur_pixel_t burst[4];
        w = (width_reg == 0) ? 1 : (width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > bb3_pkg::HEIGHT_LIMIT)
            ? int'(bb3_pkg::HEIGHT_LIMIT) : int'(height_reg);
        r = (row_pos >= h) ? h - 1 : row_pos;
        c = (col_pos >= w) ? w - 1 : col_pos;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = line_two_above[c];
        win[1][2] = line_above[c];
        win[2][2] = pix;
        line_two_above[c] = line_above[c];
        line_above[c] = pix;
        n = 0;
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                burst[n] = blur_at(r - 1, c - 1, r, c, w, h);
                n++;
            end
            if (c == w - 1)
            begin
                burst[n] = blur_at(r - 1, c, r, c, w, h);
                n++;
            end
        end
        if (r == h - 1)
        begin
            if (c >= 1)
            begin
                burst[n] = blur_at(r, c - 1, r, c, w, h);
                n++;
            end
            if (c == w - 1)
            begin
                burst[n] = blur_at(r, c, r, c, w, h);
                n++;
            end
        end
        if (n > 0)
            burst[n - 1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            blurred_q.push_back(burst[i]);
        if (c == w - 1)
        begin
            col_pos = 0;
            row_pos = (r == h - 1) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blur_pixel_t got;
        blur_pixel_t want;
        if (!rst_n)
        begin
            blurred_q.delete();
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            row_pos = 0;
            col_pos = 0;
            width_reg = 13'd640;
            height_reg = 13'd480;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = '{red_out, green_out, blue_out, out_row, out_column,
                        last_of_run, last_of_frame};
                if (blurred_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = blurred_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.row !== want.row
                        || got.col !== want.col || got.run_end !== want.run_end
                        || got.frame_end !== want.frame_end)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bb3_pkg::REG_IMAGE_WIDTH
                    || cfg_index == bb3_pkg::REG_IMAGE_HEIGHT)
                begin
                    if (cfg_index == bb3_pkg::REG_IMAGE_WIDTH)
                        width_reg = cfg_data;
                    else
                        height_reg = cfg_data;
                    row_pos = 0;
                    col_pos = 0;
                end
            end
            if (in_valid && in_ready)
                take_pixel({red_in, green_in, blue_in});
        end
    end

endmodule

// ----- tb/tb.sv -----
// Testbench top that drives pixel frames and size settings into the box blur.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [7:0]                     red_in;
    logic [7:0]                     green_in;
    logic [7:0]                     blue_in;
    logic                           out_valid;
    logic                           out_ready;
    logic [7:0]                     red_out;
    logic [7:0]                     green_out;
    logic [7:0]                     blue_out;
    logic [bb3_pkg::COORD_W-1:0]    out_row;
    logic [bb3_pkg::COORD_W-1:0]    out_column;
    logic                           last_of_run;
    logic                           last_of_frame;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [bb3_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bb3_pkg::CFG_DATA_W-1:0] cfg_data;
    int                             pending;
    int                             fail_count;
    int                             pixels_sent;
    bit                             calm;

    box_blur_3x3_edge_normalized u_top (.*);

    blur_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAIL box_blur_3x3_edge_normalized");
        $finish;
    end

    initial
    begin
        bit held;
        held = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && pixels_sent >= 50)
            begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (120) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx,
                             logic [bb3_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(int w, int h);
        wait (pending == 0);
        @(negedge clk);
        repeat (12) @(negedge clk);
        write_reg(bb3_pkg::REG_IMAGE_WIDTH, bb3_pkg::CFG_DATA_W'(w));
        write_reg(bb3_pkg::REG_IMAGE_HEIGHT, bb3_pkg::CFG_DATA_W'(h));
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        in_valid <= 1'b1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        do @(posedge clk); while (!in_ready);
        pixels_sent++;
        @(negedge clk);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    task automatic send_frame(int n, bit extremes);
        logic [7:0] pats[4];
        logic [7:0] v;
        pats = '{8'h00, 8'hFF, 8'hAA, 8'h55};
        for (int i = 0; i < n; i++)
        begin
            if (extremes)
            begin
                v = pats[i % 4];
                send_pixel(v, ~v, pats[(i / 4) % 4]);
            end
            else
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        int w;
        int h;
        int n;
        rst_n = 1'b0;
        in_valid = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pixels_sent = 0;
        calm = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_size(3, 3);
        send_frame(9, 1'b1);
        set_size(1, 1);
        send_frame(1, 1'b1);
        set_size(1, 3);
        send_frame(3, 1'b1);
        set_size(3, 1);
        send_frame(3, 1'b1);
        set_size(0, 0);
        send_frame(1, 1'b1);
        wait (pending == 0);
        @(negedge clk);
        repeat (12) @(negedge clk);
        write_reg(8'hFF, 13'h1FFF);
        write_reg(8'd2, 13'd3);
        send_frame(2, 1'b0);
        set_size(8191, 8191);
        send_frame(6, 1'b1);
        set_size(2, 8191);
        send_frame(8, 1'b0);
        set_size(4096, 1);
        send_frame(5, 1'b1);
        set_size(8, 6);
        send_frame(48, 1'b0);

        while (pixels_sent < 470)
        begin
            if (pixels_sent > 390)
                calm = 1'b1;
            w = $urandom_range(1, 10);
            h = $urandom_range(1, 8);
            n = w * h;
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, n);
            set_size(w, h);
            send_frame(n, 1'b0);
        end

        wait (pending == 0);
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("PASS box_blur_3x3_edge_normalized");
        else
            $display("FAIL box_blur_3x3_edge_normalized");
        $finish;
    end

endmodule
